@@ rtl/core/pdsr_pkg.sv @@
// pdsr_pkg: shared types and constants of the paddle shift request controller
// beat payload structs, operation codes, tracked state and configuration record
// no dependencies
package pdsr_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned StampWidth  = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgWidth-1:0] DebounceReset     = 16'd200;
  localparam logic [CfgWidth-1:0] ToggleDelayReset  = 16'd1000;
  localparam logic [CfgWidth-1:0] CheckIntervalReset = 16'd50;
  localparam logic [CfgWidth-1:0] TimeoutReset      = 16'd500;

  localparam logic [2:0] GEAR_TOP = 3'd3;

  typedef enum logic [1:0] {
    OP_UP_EDGE   = 2'd0,
    OP_DOWN_EDGE = 2'd1,
    OP_SERVICE   = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE       = 2'd0,
    CFG_TOGGLE_DELAY   = 2'd1,
    CFG_CHECK_INTERVAL = 2'd2,
    CFG_TIMEOUT        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t             operation;
    logic [StampWidth-1:0] now_ms;
    logic            up_pin_level;
    logic            down_pin_level;
    logic            in_drive;
    logic [2:0]      current_gear;
  } in_item_t;

  typedef struct packed {
    logic       up_pressed;
    logic       down_pressed;
    logic       shift_mode;
    logic       gear_write;
    logic [2:0] new_gear;
  } out_item_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ms;
    logic [CfgWidth-1:0] toggle_delay_ms;
    logic [CfgWidth-1:0] check_interval_ms;
    logic [CfgWidth-1:0] request_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                  up_request;
    logic                  down_request;
    logic [StampWidth-1:0] up_request_stamp;
    logic [StampWidth-1:0] down_request_stamp;
    logic [StampWidth-1:0] last_shift_stamp;
    logic [StampWidth-1:0] both_held_stamp;
    logic                  toggle_waiting;
    logic [StampWidth-1:0] last_check_stamp;
    logic                  up_state;
    logic                  down_state;
    logic                  mode_bit;
  } track_t;

endpackage

@@ rtl/core/pdsr_cfg_regs.sv @@
// pdsr_cfg_regs: configuration register file, write only
// depends on pdsr_pkg
module pdsr_cfg_regs import pdsr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms        <= DebounceReset;
      cfg.toggle_delay_ms    <= ToggleDelayReset;
      cfg.check_interval_ms  <= CheckIntervalReset;
      cfg.request_timeout_ms <= TimeoutReset;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:       cfg.debounce_ms        <= cfg_data;
        CFG_TOGGLE_DELAY:   cfg.toggle_delay_ms    <= cfg_data;
        CFG_CHECK_INTERVAL: cfg.check_interval_ms  <= cfg_data;
        CFG_TIMEOUT:        cfg.request_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/pdsr_step.sv @@
// pdsr_step: next tracked state and result for one event, combinational
// depends on pdsr_pkg
module pdsr_step import pdsr_pkg::*; (
  input  in_item_t  item,
  input  track_t    track,
  input  cfg_t      cfg,
  output track_t    track_next,
  output out_item_t result
);

  logic [StampWidth-1:0] since_shift;
  logic [StampWidth-1:0] since_check;
  logic [StampWidth-1:0] up_age;
  logic [StampWidth-1:0] down_age;
  logic [StampWidth-1:0] held_age;
  logic                  edge_ok;
  logic                  check_due;
  logic                  up_low;
  logic                  down_low;

  assign since_shift = item.now_ms - track.last_shift_stamp;
  assign since_check = item.now_ms - track.last_check_stamp;
  assign up_age      = item.now_ms - track.up_request_stamp;
  assign down_age    = item.now_ms - track.down_request_stamp;
  assign held_age    = item.now_ms - track.both_held_stamp;
  assign edge_ok     = since_shift >= {{(StampWidth-CfgWidth){1'b0}}, cfg.debounce_ms};
  assign check_due   = since_check >= {{(StampWidth-CfgWidth){1'b0}}, cfg.check_interval_ms};
  assign up_low      = ~item.up_pin_level;
  assign down_low    = ~item.down_pin_level;

  always_comb begin
    track_next      = track;
    result.gear_write = 1'b0;
    result.new_gear   = item.current_gear;
    case (item.operation)
      OP_UP_EDGE: begin
        if (edge_ok) begin
          if (up_low) begin
            track_next.up_request       = 1'b1;
            track_next.up_request_stamp = item.now_ms;
          end
          track_next.up_state = up_low;
        end
      end
      OP_DOWN_EDGE: begin
        if (edge_ok) begin
          if (down_low) begin
            track_next.down_request       = 1'b1;
            track_next.down_request_stamp = item.now_ms;
          end
          track_next.down_state = down_low;
        end
      end
      OP_SERVICE: begin
        // periodic resync and stale request drop, then request clear outside drive, gear shift or mode toggle
        if (check_due) begin
          track_next.up_state   = up_low;
          track_next.down_state = down_low;
          if (!up_low && track.up_request &&
              up_age > {{(StampWidth-CfgWidth){1'b0}}, cfg.request_timeout_ms}) begin
            track_next.up_request = 1'b0;
          end
          if (!down_low && track.down_request &&
              down_age > {{(StampWidth-CfgWidth){1'b0}}, cfg.request_timeout_ms}) begin
            track_next.down_request = 1'b0;
          end
          track_next.last_check_stamp = item.now_ms;
        end
        if (!item.in_drive) begin
          track_next.up_request     = 1'b0;
          track_next.down_request   = 1'b0;
          track_next.toggle_waiting = 1'b0;
        end else if (track_next.up_request && !track_next.down_request) begin
          if (item.current_gear < GEAR_TOP) begin
            result.gear_write = 1'b1;
            result.new_gear   = item.current_gear + 3'd1;
          end
          track_next.last_shift_stamp = item.now_ms;
          track_next.up_request       = 1'b0;
        end else if (track_next.down_request && !track_next.up_request) begin
          if (item.current_gear >= 3'd1 && item.current_gear <= GEAR_TOP) begin
            result.gear_write = 1'b1;
            result.new_gear   = item.current_gear - 3'd1;
          end
          track_next.last_shift_stamp = item.now_ms;
          track_next.down_request     = 1'b0;
        end else if (track_next.up_request && track_next.down_request) begin
          if (!track.toggle_waiting) begin
            track_next.both_held_stamp = item.now_ms;
            track_next.toggle_waiting  = 1'b1;
          end else if (held_age >= {{(StampWidth-CfgWidth){1'b0}}, cfg.toggle_delay_ms}) begin
            track_next.mode_bit       = ~track.mode_bit;
            track_next.toggle_waiting = 1'b0;
            track_next.up_request     = 1'b0;
            track_next.down_request   = 1'b0;
          end
        end else begin
          track_next.toggle_waiting = 1'b0;
        end
      end
      default: ;
    endcase
    result.up_pressed   = track_next.up_state;
    result.down_pressed = track_next.down_state;
    result.shift_mode   = track_next.mode_bit;
  end

endmodule

@@ rtl/core/paddle_shift_request_controller.sv @@
// paddle_shift_request_controller: top level, input register, tracked state, result register
// depends on pdsr_pkg, pdsr_cfg_regs, pdsr_step
// an accepted input beat passes the input register and then the result register to reach out_valid
// throughput: one beat per cycle while out_stall is low; the event is resolved combinationally by pdsr_step
// between the input register and the result register, which also updates the state
// reset: synchronous, active high; clears beat valids, tracked state and mode,
// and loads the configuration reset values
module paddle_shift_request_controller import pdsr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data
);

  cfg_t      cfg;
  track_t    track;
  track_t    track_next;
  out_item_t result;

  // input register stage
  logic      hold_valid;
  in_item_t  hold_data;

  logic      out_free;
  logic      advance;
  logic      take;

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  // held beat moves into the result register and commits its state update
  assign advance  = hold_valid && out_free;
  // input register is free when empty or emptying
  assign in_stall = hold_valid && !out_free;
  assign take     = in_valid && !in_stall;

  pdsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdsr_step u_step (
    .item       (hold_data),
    .track      (track),
    .cfg        (cfg),
    .track_next (track_next),
    .result     (result)
  );

  // beat valids
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      hold_data <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // tracked state, updated once per event as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      track <= '0;
    end else if (advance) begin
      track <= track_next;
    end
  end

`ifndef ASSERT_OFF
  // a stalled input implies a full, blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a commanded gear is always a real gear
  a_gear_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.gear_write) |-> (out_data.new_gear <= GEAR_TOP))
    else $error("commanded gear out of range");

  // mode only flips when an event commits
  a_mode_commit: assert property (@(posedge clk) disable iff (rst)
    !$stable(track.mode_bit) |-> ($past(advance) || $past(rst)))
    else $error("mode changed without an event");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
